// File: hdl/bytecode_instruction_decoder_core_defines.svh
// ----------------------------------------------------------------------------
// Bytecode instruction decoder - assertion macros
// Shared property templates for the decoder's concurrent checks.
// ----------------------------------------------------------------------------
`ifndef BYTECODE_INSTRUCTION_DECODER_CORE_DEFINES_SVH
`define BYTECODE_INSTRUCTION_DECODER_CORE_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define BID_ASSERT_NOW(label, clk, rst_n, cond, expr) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (cond) |-> (expr)) \
        else $error("decoder check failed");

// Next-cycle implication, disabled while reset is asserted.
`define BID_ASSERT_NEXT(label, clk, rst_n, cond, expr) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (cond) |=> (expr)) \
        else $error("decoder check failed");

`endif

// File: hdl/bid_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Bytecode instruction decoder - package
// Result record type, format codes and opcode tables.
// ----------------------------------------------------------------------------
package bid_pkg;

    localparam int TDATA_W = 104;

    localparam logic [2:0] FMT_BARE   = 3'd0;
    localparam logic [2:0] FMT_RD     = 3'd1;
    localparam logic [2:0] FMT_RD_SRC = 3'd2;
    localparam logic [2:0] FMT_IMM    = 3'd3;
    localparam logic [2:0] FMT_JUMP   = 3'd4;
    localparam logic [2:0] FMT_SKIP   = 3'd5;

    localparam logic KIND_INSTR   = 1'b0;
    localparam logic KIND_PAYLOAD = 1'b1;

    // Named opcode set, one bit per opcode value.
    localparam logic [255:0] KNOWN_SET = {
        32'h0000_0000, 32'h0000_0000, 32'h0000_0000, 32'h0000_0003,
        32'h0001_03DF, 32'h0000_033F, 32'h07C0_C97F, 32'hFFFF_FFFF
    };

    typedef struct packed {
        logic        kind;
        logic [15:0] addr;
        logic [7:0]  opcode;
        logic        known;
        logic [2:0]  fmt;
        logic [7:0]  dest;
        logic [7:0]  src;
        logic [15:0] imm;
        logic [17:0] jt;
        logic        back;
        logic [15:0] plen;
        logic [7:0]  pbyte;
    } t_result;

    function automatic logic [2:0] format_of(input logic [7:0] op);
        logic [2:0] f;
        case (op)
            8'h0D, 8'h0E, 8'h0F, 8'h44, 8'h21, 8'h22,
            8'h60, 8'h61, 8'h62, 8'h25, 8'h26: f = FMT_RD;
            8'h01, 8'h02, 8'h03, 8'h08, 8'h09, 8'h0A,
            8'h0B, 8'h0C, 8'h10, 8'h11, 8'h12, 8'h13,
            8'h14, 8'h15, 8'h16, 8'h17, 8'h18, 8'h19,
            8'h1A, 8'h1B, 8'h1C, 8'h1D, 8'h1E, 8'h1F,
            8'h20, 8'h38, 8'h39, 8'h3A, 8'h40, 8'h41,
            8'h42, 8'h43, 8'h48, 8'h49: f = FMT_RD_SRC;
            8'h2B: f = FMT_IMM;
            8'h04, 8'h05, 8'h06, 8'h07, 8'h2E, 8'h2F,
            8'h36, 8'h37: f = FMT_JUMP;
            8'h63, 8'h64, 8'h66, 8'h67, 8'h68, 8'h69,
            8'h70: f = FMT_SKIP;
            default: f = FMT_BARE;
        endcase
        return f;
    endfunction

endpackage

// File: hdl/bytecode_instruction_decoder_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Bytecode instruction decoder core
// Streams a variable-length bytecode program in and decoded records out.
// ----------------------------------------------------------------------------
// One program byte is taken per transfer and the block sustains one byte per
// clock while the result register is not stalled: each byte passes from the
// input register through a single pass of the phase machine into the result
// register. A byte is accepted whenever the input register is empty or moves
// on, which it does whenever the result register is empty or being drained.
// Bytes at or beyond program_length give nothing.
// Write program_length only while no transfer is in flight.
`include "bytecode_instruction_decoder_core_defines.svh"

module bytecode_instruction_decoder_core #(
    parameter int ADDR_BITS = 16
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_cfg_wr_en,
    input  logic [15:0]                 i_cfg_wr_data,
    input  logic                        i_s_tvalid,
    output logic                        o_s_tready,
    // [7:0] byte_value
    input  logic [7:0]                  i_s_tdata,
    output logic                        o_m_tvalid,
    input  logic                        i_m_tready,
    // [15:0] address, [23:16] opcode, [24] known_opcode, [27:25] format,
    // [35:28] dest_reg, [43:36] src_reg, [59:44] immediate,
    // [77:60] jump_target, [78] backward, [94:79] payload_length,
    // [102:95] payload_byte, [103] zero
    output logic [bid_pkg::TDATA_W-1:0] o_m_tdata,
    // [0] kind
    output logic                        o_m_tuser
);

    logic             r_in_valid;
    logic [7:0]       r_in_byte;
    logic             r_out_valid;
    bid_pkg::t_result r_out;

    logic             adv;
    logic             step;
    logic             res_valid;
    bid_pkg::t_result res;

    assign adv        = !r_out_valid || i_m_tready;
    assign step       = r_in_valid && adv;
    assign o_s_tready = !r_in_valid || adv;

    bid_decode #(
        .ADDR_BITS (ADDR_BITS)
    ) u_decode (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .i_step        (step),
        .i_byte        (r_in_byte),
        .o_res_valid   (res_valid),
        .o_res         (res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (o_s_tready) begin
                r_in_valid <= i_s_tvalid;
            end
            if (adv) begin
                r_out_valid <= res_valid;
            end
        end
    end

    // Payload registers: load on transfer or on a new record.
    always_ff @(posedge i_clk) begin
        if (o_s_tready && i_s_tvalid) begin
            r_in_byte <= i_s_tdata;
        end
        if (adv && res_valid) begin
            r_out <= res;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tuser  = r_out.kind;
    assign o_m_tdata  = {1'b0, r_out.pbyte, r_out.plen, r_out.back, r_out.jt,
                         r_out.imm, r_out.src, r_out.dest, r_out.fmt, r_out.known,
                         r_out.opcode, r_out.addr};

    `BID_ASSERT_NEXT(a_in_hold, i_clk, i_rst_n, r_in_valid && !adv,
        r_in_valid && $stable(r_in_byte))
    `BID_ASSERT_NOW(a_payload_fmt, i_clk, i_rst_n, r_out_valid && r_out.kind,
        r_out.fmt == bid_pkg::FMT_SKIP && r_out.plen == 16'd0)
    `BID_ASSERT_NOW(a_back_jump, i_clk, i_rst_n, r_out_valid && r_out.back,
        r_out.fmt == bid_pkg::FMT_JUMP && r_out.kind == bid_pkg::KIND_INSTR)

endmodule

// File: hdl/bid_decode.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Bytecode instruction decoder - phase machine
// Holds the program length, byte position and partial instruction, and
// forms the result record for the byte presented on a step.
// ----------------------------------------------------------------------------
module bid_decode #(
    parameter int ADDR_BITS = 16
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_wr_en,
    input  logic [15:0]        i_cfg_wr_data,
    input  logic               i_step,
    input  logic [7:0]         i_byte,
    output logic               o_res_valid,
    output bid_pkg::t_result   o_res
);

    // Compare width: position and length never wrap in the bound checks.
    localparam int CW = ((ADDR_BITS > 16) ? ADDR_BITS : 16) + 2;
    // Jump target width: next position plus a signed 16-bit offset.
    localparam int TW = ((ADDR_BITS >= 17) ? ADDR_BITS + 1 : 17) + 1;

    localparam logic [2:0] PH_OPCODE  = 3'd0;
    localparam logic [2:0] PH_RD      = 3'd1;
    localparam logic [2:0] PH_RS      = 3'd2;
    localparam logic [2:0] PH_IMM_LO  = 3'd3;
    localparam logic [2:0] PH_IMM_HI  = 3'd4;
    localparam logic [2:0] PH_SKIP_LO = 3'd5;
    localparam logic [2:0] PH_SKIP_HI = 3'd6;
    localparam logic [2:0] PH_PAYLOAD = 3'd7;

    logic [15:0]          r_prog_len;
    logic [ADDR_BITS-1:0] r_pos,   n_pos;
    logic [2:0]           r_phase, n_phase;
    logic [7:0]           r_op,    n_op;
    logic [ADDR_BITS-1:0] r_addr,  n_addr;
    logic [7:0]           r_dest,  n_dest;
    logic [7:0]           r_src,   n_src;
    logic [7:0]           r_low,   n_low;
    logic [15:0]          r_left,  n_left;

    logic [CW-1:0] p_ext, len_ext, nxt_ext, p2_ext;
    logic          live, take;
    logic [15:0]   skip, imm, plen;
    logic [2:0]    fmt_new, fmt_held, fmt_rec;
    logic          emit_i, emit_p;
    logic [TW-1:0] nxt_t, tgt;
    logic          back;

    assign p_ext    = CW'(r_pos);
    assign len_ext  = CW'(r_prog_len);
    assign nxt_ext  = p_ext + CW'(1);
    assign p2_ext   = p_ext + CW'(2);
    assign live     = p_ext < len_ext;
    assign take     = i_step && live;
    assign skip     = {i_byte, r_low};
    assign fmt_new  = bid_pkg::format_of(i_byte);
    assign fmt_held = bid_pkg::format_of(r_op);

    always_comb begin
        n_pos   = r_pos + ADDR_BITS'(1);
        n_phase = r_phase;
        n_op    = r_op;
        n_addr  = r_addr;
        n_dest  = r_dest;
        n_src   = r_src;
        n_low   = r_low;
        n_left  = r_left;
        emit_i  = 1'b0;
        emit_p  = 1'b0;
        imm     = 16'd0;
        plen    = 16'd0;
        case (r_phase)
            PH_OPCODE: begin
                n_op   = i_byte;
                n_addr = r_pos;
                n_dest = 8'd0;
                n_src  = 8'd0;
                n_low  = 8'd0;
                if (fmt_new == bid_pkg::FMT_BARE) begin
                    emit_i = 1'b1;
                end else if (fmt_new == bid_pkg::FMT_SKIP) begin
                    if (p2_ext < len_ext) begin
                        n_phase = PH_SKIP_LO;
                    end else begin
                        emit_i = 1'b1;
                    end
                end else if (nxt_ext < len_ext) begin
                    n_phase = PH_RD;
                end else begin
                    emit_i = 1'b1;
                end
            end
            PH_RD: begin
                n_dest = i_byte;
                if (fmt_held == bid_pkg::FMT_RD_SRC && nxt_ext < len_ext) begin
                    n_phase = PH_RS;
                end else if ((fmt_held == bid_pkg::FMT_IMM || fmt_held == bid_pkg::FMT_JUMP)
                             && p2_ext < len_ext) begin
                    n_phase = PH_IMM_LO;
                end else begin
                    emit_i  = 1'b1;
                    n_phase = PH_OPCODE;
                end
            end
            PH_RS: begin
                n_src   = i_byte;
                emit_i  = 1'b1;
                n_phase = PH_OPCODE;
            end
            PH_IMM_LO: begin
                n_low   = i_byte;
                n_phase = PH_IMM_HI;
            end
            PH_IMM_HI: begin
                imm     = skip;
                emit_i  = 1'b1;
                n_phase = PH_OPCODE;
            end
            PH_SKIP_LO: begin
                n_low   = i_byte;
                n_phase = PH_SKIP_HI;
            end
            PH_SKIP_HI: begin
                emit_i = 1'b1;
                // Drop the payload if it would run past the program end.
                if (skip != 16'd0 && nxt_ext + CW'(skip) <= len_ext) begin
                    n_left  = skip;
                    plen    = skip;
                    n_phase = PH_PAYLOAD;
                end else begin
                    n_phase = PH_OPCODE;
                end
            end
            PH_PAYLOAD: begin
                emit_p = 1'b1;
                if (r_left != 16'd0) begin
                    n_left = r_left - 16'd1;
                end
                if (n_left == 16'd0) begin
                    n_phase = PH_OPCODE;
                end
            end
            default: begin
                n_phase = PH_OPCODE;
            end
        endcase
    end

    // Target from the position after the bytes consumed so far.
    assign fmt_rec = bid_pkg::format_of(n_op);
    assign nxt_t   = TW'(r_pos) + TW'(1);
    assign tgt     = nxt_t + {{(TW-16){imm[15]}}, imm};
    assign back    = !tgt[TW-1] && (tgt <= TW'(n_addr));

    always_comb begin
        o_res.kind   = bid_pkg::KIND_INSTR;
        o_res.addr   = 16'(n_addr);
        o_res.opcode = n_op;
        o_res.known  = bid_pkg::KNOWN_SET[n_op];
        o_res.fmt    = fmt_rec;
        o_res.dest   = n_dest;
        o_res.src    = n_src;
        o_res.imm    = imm;
        o_res.jt     = (fmt_rec == bid_pkg::FMT_JUMP) ? tgt[17:0] : 18'd0;
        o_res.back   = (fmt_rec == bid_pkg::FMT_JUMP) ? back : 1'b0;
        o_res.plen   = plen;
        o_res.pbyte  = 8'd0;
        if (emit_p) begin
            o_res.kind  = bid_pkg::KIND_PAYLOAD;
            o_res.addr  = 16'(r_pos);
            o_res.fmt   = bid_pkg::FMT_SKIP;
            o_res.dest  = 8'd0;
            o_res.src   = 8'd0;
            o_res.jt    = 18'd0;
            o_res.back  = 1'b0;
            o_res.plen  = 16'd0;
            o_res.pbyte = i_byte;
        end
    end

    assign o_res_valid = take && (emit_i || emit_p);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prog_len <= 16'd0;
            r_pos      <= '0;
            r_phase    <= PH_OPCODE;
            r_op       <= 8'd0;
            r_addr     <= '0;
            r_dest     <= 8'd0;
            r_src      <= 8'd0;
            r_low      <= 8'd0;
            r_left     <= 16'd0;
        end else begin
            if (i_cfg_wr_en) begin
                r_prog_len <= i_cfg_wr_data;
            end
            // Bytes at or beyond the program end leave all state untouched.
            if (take) begin
                r_pos   <= n_pos;
                r_phase <= n_phase;
                r_op    <= n_op;
                r_addr  <= n_addr;
                r_dest  <= n_dest;
                r_src   <= n_src;
                r_low   <= n_low;
                r_left  <= n_left;
            end
        end
    end

endmodule
